>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the exposure value converter.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/lve_pkg.sv
// ---------------------------------------------------------------------------
// lve_pkg
// Types and constants shared by the exposure value converter pipeline.
// ---------------------------------------------------------------------------
package lve_pkg;

    localparam int LVE_STAGES_DEF = 5;
    localparam int LVE_PER_STAGE  = 16;
    localparam int LVE_TEMP_DEPTH = 64;
    localparam int LVE_STAGE_W    = 3;
    localparam int LVE_NIB_W      = 4;
    localparam int LVE_ROW_W      = LVE_STAGE_W + LVE_NIB_W;
    localparam int LVE_TIDX_W     = 6;
    localparam int LVE_BITS_W     = 16;
    localparam int LVE_ONES_W     = 5;
    localparam int LVE_SUM_W      = 10;

    localparam logic [LVE_NIB_W-1:0]  LVE_NIB_MAX  = 4'h0F;
    localparam logic [LVE_BITS_W-1:0] LVE_MASK_ALL = 16'hFFFF;
    localparam logic [7:0]            LVE_EV_MAX   = 8'hFF;
    localparam logic signed [LVE_SUM_W-1:0] LVE_SUM_MAX = 10'sd255;

    typedef enum logic {
        MODE_QUERY = 1'b0,
        MODE_WRITE = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        SEL_BASE    = 2'd0,
        SEL_PAIR    = 2'd1,
        SEL_PATTERN = 2'd2,
        SEL_TEMP    = 2'd3
    } t_sel;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FLOOR     = 3'd1,
        ST_CAP       = 3'd2,
        ST_BAD_STAGE = 3'd3,
        ST_WRITTEN   = 3'd4
    } t_status;

    typedef struct packed {
        t_mode                  mode;
        t_sel                   sel;
        logic [LVE_STAGE_W-1:0] stage;
        logic [5:0]             idx;
        logic [7:0]             val;
        logic [LVE_TIDX_W-1:0]  tidx;
        logic [7:0]             volt;
        logic                   bad;
    } t_req;

    typedef struct packed {
        logic [7:0] base;
        logic [7:0] pair;
        logic [7:0] adj;
    } t_look;

    typedef struct packed {
        logic [7:0]            base;
        logic [7:0]            adj;
        logic [LVE_BITS_W-1:0] bits;
    } t_pat;

    typedef struct packed {
        logic [7:0]            base;
        logic [7:0]            adj;
        logic [LVE_ONES_W-1:0] ones;
    } t_cnt;

endpackage

>>> rtl/light_voltage_to_exposure_value_top.sv
// ---------------------------------------------------------------------------
// light_voltage_to_exposure_value_top
// Table-driven light voltage to exposure value converter, five-stage pipeline.
// ---------------------------------------------------------------------------
// One request enters per clock while no stall holds the pipeline, and every
// request, query or table write, returns one result. The pipeline has five
// register stages: request capture with offset subtraction, the
// base/index-pair/temperature table read, the pattern table read, the masked
// bit count, and the sum with saturation. Each table is written at the stage
// where it is read, so a query sees every write taken before it. Tables come
// up unwritten; fill every entry a query can reach before querying. The
// voltage offset may change only while the pipeline is empty.
`include "assert_macros.svh"

module light_voltage_to_exposure_value_top #(
    parameter int STAGES = lve_pkg::LVE_STAGES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_mode,
    input  logic [1:0] i_table_select,
    input  logic [2:0] i_stage,
    input  logic [5:0] i_entry_index,
    input  logic [7:0] i_entry_value,
    input  logic [7:0] i_temperature,
    input  logic [7:0] i_voltage,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_exposure_value,
    output logic [2:0] o_status
);
    import lve_pkg::*;

    logic  w_s1_valid;
    logic  w_s1_stall;
    t_req  w_s1_req;
    logic  w_s2_valid;
    logic  w_s2_stall;
    t_req  w_s2_req;
    t_look w_s2_look;
    logic  w_s3_valid;
    logic  w_s3_stall;
    t_req  w_s3_req;
    t_pat  w_s3_pat;

    lve_front #(.STAGES(STAGES)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_table_select (i_table_select),
        .i_stage        (i_stage),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .i_temperature  (i_temperature),
        .i_voltage      (i_voltage),
        .o_valid        (w_s1_valid),
        .o_req          (w_s1_req),
        .i_stall        (w_s1_stall)
    );

    lve_lookup #(.STAGES(STAGES)) u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .i_req   (w_s1_req),
        .o_stall (w_s1_stall),
        .o_valid (w_s2_valid),
        .o_req   (w_s2_req),
        .o_look  (w_s2_look),
        .i_stall (w_s2_stall)
    );

    lve_pattern #(.STAGES(STAGES)) u_pattern (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s2_valid),
        .i_req   (w_s2_req),
        .i_look  (w_s2_look),
        .o_stall (w_s2_stall),
        .o_valid (w_s3_valid),
        .o_req   (w_s3_req),
        .o_pat   (w_s3_pat),
        .i_stall (w_s3_stall)
    );

    lve_sum u_sum (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_s3_valid),
        .i_req            (w_s3_req),
        .i_pat            (w_s3_pat),
        .o_stall          (w_s3_stall),
        .o_valid          (o_valid),
        .o_exposure_value (o_exposure_value),
        .o_status         (o_status),
        .i_stall          (i_stall)
    );

    `ASSERT_NEXT(a_take_fills_front, i_clk, i_rst_n, i_valid && !o_stall, w_s1_valid)
    `ASSERT_IMPLY(a_zero_value_codes, i_clk, i_rst_n,
        o_valid && (o_status == ST_WRITTEN || o_status == ST_BAD_STAGE
        || o_status == ST_FLOOR), o_exposure_value == 8'd0)
    `ASSERT_IMPLY(a_cap_value, i_clk, i_rst_n,
        o_valid && (o_status == ST_CAP), o_exposure_value == LVE_EV_MAX)
    `ASSERT_NEXT(a_front_holds, i_clk, i_rst_n, w_s1_valid && w_s1_stall,
        w_s1_valid && $stable(w_s1_req))

endmodule

>>> rtl/lve_front.sv
// ---------------------------------------------------------------------------
// lve_front
// Offset register, request capture and offset subtraction with floor.
// ---------------------------------------------------------------------------
module lve_front #(
    parameter int STAGES = lve_pkg::LVE_STAGES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_mode,
    input  logic [1:0]    i_table_select,
    input  logic [2:0]    i_stage,
    input  logic [5:0]    i_entry_index,
    input  logic [7:0]    i_entry_value,
    input  logic [7:0]    i_temperature,
    input  logic [7:0]    i_voltage,
    output logic          o_valid,
    output lve_pkg::t_req o_req,
    input  logic          i_stall
);
    import lve_pkg::*;

    logic [7:0] r_offset;
    logic       r_valid;
    t_req       r_req;
    t_req       n_req;
    logic       w_take;

    assign o_stall = r_valid && i_stall;
    assign w_take  = i_valid && !o_stall;

    always_comb begin
        n_req.mode  = t_mode'(i_mode);
        n_req.sel   = t_sel'(i_table_select);
        n_req.stage = i_stage;
        n_req.idx   = i_entry_index;
        n_req.val   = i_entry_value;
        n_req.tidx  = i_temperature[7:2];
        n_req.volt  = (i_voltage >= r_offset) ? (i_voltage - r_offset) : 8'd0;
        n_req.bad   = (i_stage >= LVE_STAGE_W'(STAGES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= 8'd0;
        end else if (i_cfg_we) begin
            r_offset <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_req <= n_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

>>> rtl/lve_lookup.sv
// ---------------------------------------------------------------------------
// lve_lookup
// Base, index pair and temperature tables: write and registered read.
// ---------------------------------------------------------------------------
module lve_lookup #(
    parameter int STAGES = lve_pkg::LVE_STAGES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  lve_pkg::t_req  i_req,
    output logic           o_stall,
    output logic           o_valid,
    output lve_pkg::t_req  o_req,
    output lve_pkg::t_look o_look,
    input  logic           i_stall
);
    import lve_pkg::*;

    localparam int DEPTH  = STAGES * LVE_PER_STAGE;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [7:0] r_base_mem [DEPTH];
    logic [7:0] r_pair_mem [DEPTH];
    logic [7:0] r_temp_mem [LVE_TEMP_DEPTH];

    logic                 r_valid;
    t_req                 r_req;
    t_look                r_look;
    logic                 w_take;
    logic                 w_stage_wr;
    logic [LVE_ROW_W-1:0] w_rd_row;
    logic [LVE_ROW_W-1:0] w_wr_row;
    logic [ADDR_W-1:0]    w_rd_addr;
    logic [ADDR_W-1:0]    w_wr_addr;

    assign o_stall    = r_valid && i_stall;
    assign w_take     = i_valid && !o_stall;
    assign w_stage_wr = w_take && (i_req.mode == MODE_WRITE) && !i_req.bad
                        && (i_req.idx[5:4] == 2'b00);
    assign w_rd_row   = {i_req.stage, i_req.volt[7:4]};
    assign w_wr_row   = {i_req.stage, i_req.idx[3:0]};
    assign w_rd_addr  = w_rd_row[ADDR_W-1:0];
    assign w_wr_addr  = w_wr_row[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_stage_wr && (i_req.sel == SEL_BASE)) begin
            r_base_mem[w_wr_addr] <= i_req.val;
        end
        if (w_stage_wr && (i_req.sel == SEL_PAIR)) begin
            r_pair_mem[w_wr_addr] <= i_req.val;
        end
        if (w_take && (i_req.mode == MODE_WRITE) && (i_req.sel == SEL_TEMP)) begin
            r_temp_mem[i_req.idx] <= i_req.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_look.base <= r_base_mem[w_rd_addr];
            r_look.pair <= r_pair_mem[w_rd_addr];
            r_look.adj  <= r_temp_mem[i_req.tidx];
            r_req       <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;
    assign o_look  = r_look;

endmodule

>>> rtl/lve_pattern.sv
// ---------------------------------------------------------------------------
// lve_pattern
// Pattern table: one write port, two registered reads for the byte pair.
// ---------------------------------------------------------------------------
module lve_pattern #(
    parameter int STAGES = lve_pkg::LVE_STAGES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  lve_pkg::t_req  i_req,
    input  lve_pkg::t_look i_look,
    output logic           o_stall,
    output logic           o_valid,
    output lve_pkg::t_req  o_req,
    output lve_pkg::t_pat  o_pat,
    input  logic           i_stall
);
    import lve_pkg::*;

    localparam int DEPTH  = STAGES * LVE_PER_STAGE;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [7:0] r_pat_mem [DEPTH];

    logic                 r_valid;
    t_req                 r_req;
    t_pat                 r_pat;
    logic                 w_take;
    logic                 w_wr;
    logic [LVE_ROW_W-1:0] w_hi_row;
    logic [LVE_ROW_W-1:0] w_lo_row;
    logic [LVE_ROW_W-1:0] w_wr_row;

    assign o_stall  = r_valid && i_stall;
    assign w_take   = i_valid && !o_stall;
    assign w_wr     = w_take && (i_req.mode == MODE_WRITE) && (i_req.sel == SEL_PATTERN)
                      && !i_req.bad && (i_req.idx[5:4] == 2'b00);
    assign w_hi_row = {i_req.stage, i_look.pair[7:4]};
    assign w_lo_row = {i_req.stage, i_look.pair[3:0]};
    assign w_wr_row = {i_req.stage, i_req.idx[3:0]};

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_pat_mem[w_wr_row[ADDR_W-1:0]] <= i_req.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pat.bits <= {r_pat_mem[w_hi_row[ADDR_W-1:0]], r_pat_mem[w_lo_row[ADDR_W-1:0]]};
            r_pat.base <= i_look.base;
            r_pat.adj  <= i_look.adj;
            r_req      <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;
    assign o_pat   = r_pat;

endmodule

>>> rtl/lve_sum.sv
// ---------------------------------------------------------------------------
// lve_sum
// Masked bit count, signed sum with temperature correction, saturation.
// ---------------------------------------------------------------------------
module lve_sum (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  lve_pkg::t_req i_req,
    input  lve_pkg::t_pat i_pat,
    output logic          o_stall,
    output logic          o_valid,
    output logic [7:0]    o_exposure_value,
    output logic [2:0]    o_status,
    input  logic          i_stall
);
    import lve_pkg::*;

    logic                        r_cnt_valid;
    t_req                        r_req;
    t_cnt                        r_cnt;
    t_cnt                        n_cnt;
    logic                        w_cnt_stall;
    logic                        w_cnt_take;
    logic [LVE_BITS_W-1:0]       w_mask;

    logic                        r_out_valid;
    logic [7:0]                  r_ev;
    t_status                     r_status;
    logic [7:0]                  n_ev;
    t_status                     n_status;
    logic                        w_out_stall;
    logic signed [LVE_SUM_W-1:0] w_sum;

    assign w_out_stall = r_out_valid && i_stall;
    assign w_cnt_stall = r_cnt_valid && w_out_stall;
    assign o_stall     = w_cnt_stall;
    assign w_cnt_take  = i_valid && !w_cnt_stall;

    // keep the top (low nibble + 1) bits of the byte pair
    assign w_mask = LVE_MASK_ALL << (LVE_NIB_MAX - i_req.volt[3:0]);

    always_comb begin
        n_cnt.base = i_pat.base;
        n_cnt.adj  = i_pat.adj;
        n_cnt.ones = LVE_ONES_W'($countones(i_pat.bits & w_mask));
    end

    always_ff @(posedge i_clk) begin
        if (w_cnt_take) begin
            r_cnt <= n_cnt;
            r_req <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_valid <= 1'b0;
        end else if (!w_cnt_stall) begin
            r_cnt_valid <= i_valid;
        end
    end

    assign w_sum = $signed({2'b00, r_cnt.base})
                 + $signed({{(LVE_SUM_W-LVE_ONES_W){1'b0}}, r_cnt.ones})
                 + $signed({{(LVE_SUM_W-8){r_cnt.adj[7]}}, r_cnt.adj});

    always_comb begin
        n_ev     = 8'd0;
        n_status = ST_OK;
        if (r_req.mode == MODE_WRITE) begin
            n_status = ((r_req.sel != SEL_TEMP) && r_req.bad) ? ST_BAD_STAGE : ST_WRITTEN;
        end else if (r_req.bad) begin
            n_status = ST_BAD_STAGE;
        end else if (w_sum < 0) begin
            n_status = ST_FLOOR;
        end else if (w_sum > LVE_SUM_MAX) begin
            n_status = ST_CAP;
            n_ev     = LVE_EV_MAX;
        end else begin
            n_ev     = w_sum[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cnt_valid && !w_out_stall) begin
            r_ev     <= n_ev;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!w_out_stall) begin
            r_out_valid <= r_cnt_valid;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_exposure_value = r_ev;
    assign o_status         = r_status;

endmodule

>>> verif/light_voltage_to_exposure_value_checker.sv
// ----------------------------------------------------------------------------
// light_voltage_to_exposure_value_checker
// Watches the request, result and register ports of the exposure value
// converter. It keeps its own copy of the four tables and the voltage offset,
// works out the result of each accepted request and compares each accepted
// result, field by field, with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module light_voltage_to_exposure_value_checker #(
    parameter int STAGES = lve_pkg::LVE_STAGES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_req_valid,
    input  logic       i_req_stall,
    input  logic       i_mode,
    input  logic [1:0] i_table_select,
    input  logic [2:0] i_stage,
    input  logic [5:0] i_entry_index,
    input  logic [7:0] i_entry_value,
    input  logic [7:0] i_temperature,
    input  logic [7:0] i_voltage,
    input  logic       i_res_valid,
    input  logic       i_res_stall,
    input  logic [7:0] i_exposure_value,
    input  logic [2:0] i_status,
    output int         o_outstanding,
    output int         o_failures
);
    timeunit 1ns;
    timeprecision 1ps;

    import lve_pkg::*;

    typedef struct packed {
        logic [7:0] exposure_value;
        t_status    status;
    } t_exposure_result;

    logic [7:0] base_vals     [LVE_PER_STAGE*STAGES];
    logic [7:0] pair_nibbles  [LVE_PER_STAGE*STAGES];
    logic [7:0] pattern_bytes [LVE_PER_STAGE*STAGES];
    logic [7:0] temp_corr     [LVE_TEMP_DEPTH];
    logic [7:0] voltage_offset = '0;

    t_exposure_result expected_results[$];
    int fail_count = 0;

    function automatic t_exposure_result convert_request(
        input t_mode      mode,
        input t_sel       sel,
        input logic [2:0] stage,
        input logic [5:0] idx,
        input logic [7:0] val,
        input logic [7:0] temp,
        input logic [7:0] volt
    );
        t_exposure_result r;
        logic [7:0]  v;
        logic [4:0]  keep;
        logic [7:0]  pair;
        logic [15:0] bits;
        logic [15:0] mask;
        int          row;
        int          sum;
        r.exposure_value = '0;
        r.status         = ST_OK;
        if (mode == MODE_WRITE) begin
            if (sel == SEL_TEMP) begin
                temp_corr[idx] = val;
                r.status = ST_WRITTEN;
            end else if (stage >= STAGES) begin
                r.status = ST_BAD_STAGE;
            end else begin
                if (idx < LVE_PER_STAGE) begin
                    row = stage * LVE_PER_STAGE + idx;
                    case (sel)
                        SEL_BASE: base_vals[row]     = val;
                        SEL_PAIR: pair_nibbles[row]  = val;
                        default:  pattern_bytes[row] = val;
                    endcase
                end
                r.status = ST_WRITTEN;
            end
        end else if (stage >= STAGES) begin
            r.status = ST_BAD_STAGE;
        end else begin
            v    = (volt >= voltage_offset) ? volt - voltage_offset : 8'd0;
            row  = stage * LVE_PER_STAGE + v[7:4];
            keep = {1'b0, v[3:0]} + 5'd1;
            pair = pair_nibbles[row];
            bits = {pattern_bytes[stage * LVE_PER_STAGE + pair[7:4]],
                    pattern_bytes[stage * LVE_PER_STAGE + pair[3:0]]};
            mask = 16'hFFFF << (16 - keep);
            sum  = int'(base_vals[row]) + $countones(bits & mask)
                 + int'($signed(temp_corr[temp[7:2]]));
            if (sum < 0) begin
                r.status = ST_FLOOR;
            end else if (sum > 255) begin
                r.exposure_value = 8'hFF;
                r.status         = ST_CAP;
            end else begin
                r.exposure_value = sum[7:0];
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_exposure_result want;
        if (!i_rst_n) begin
            expected_results.delete();
            voltage_offset = '0;
        end else begin
            if (i_cfg_we) begin
                voltage_offset = i_cfg_wdata;
            end
            if (i_req_valid && !i_req_stall) begin
                expected_results.push_back(convert_request(t_mode'(i_mode),
                    t_sel'(i_table_select), i_stage, i_entry_index, i_entry_value,
                    i_temperature, i_voltage));
            end
            if (i_res_valid && !i_res_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: exposure_value %0d status %0d",
                           i_exposure_value, i_status);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_exposure_value !== want.exposure_value) begin
                        $error("exposure_value mismatch: expected %0d, actual %0d",
                               want.exposure_value, i_exposure_value);
                        fail_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_status);
                        fail_count++;
                    end
                end
            end
        end
        o_outstanding <= expected_results.size();
        o_failures    <= fail_count;
    end

endmodule

>>> verif/light_voltage_to_exposure_value_top_tb.sv
// ----------------------------------------------------------------------------
// light_voltage_to_exposure_value_top_tb
// Fills every table of the converter, runs a short directed set of table
// writes and queries at the field extremes, then random requests under three
// idling mixes and several voltage offsets, including one long result
// hold-off that backs the pipeline up. The checker beside the block predicts
// and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module light_voltage_to_exposure_value_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lve_pkg::*;

    localparam int STAGES         = LVE_STAGES_DEF;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_REQUESTS = 524;
    localparam int DRAIN_CYCLES   = 20;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_cfg_we       = 1'b0;
    logic [7:0] i_cfg_wdata    = '0;
    logic       i_valid        = 1'b0;
    logic       o_stall;
    logic       i_mode         = 1'b0;
    logic [1:0] i_table_select = '0;
    logic [2:0] i_stage        = '0;
    logic [5:0] i_entry_index  = '0;
    logic [7:0] i_entry_value  = '0;
    logic [7:0] i_temperature  = '0;
    logic [7:0] i_voltage      = '0;
    logic       o_valid;
    logic       i_stall        = 1'b0;
    logic [7:0] o_exposure_value;
    logic [2:0] o_status;

    int outstanding;
    int failures;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;
    int hold_left     = 0;
    logic hold_arm    = 1'b0;
    logic hold_taken  = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    light_voltage_to_exposure_value_top #(
        .STAGES(STAGES)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_table_select  (i_table_select),
        .i_stage         (i_stage),
        .i_entry_index   (i_entry_index),
        .i_entry_value   (i_entry_value),
        .i_temperature   (i_temperature),
        .i_voltage       (i_voltage),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_exposure_value(o_exposure_value),
        .o_status        (o_status)
    );

    light_voltage_to_exposure_value_checker #(
        .STAGES(STAGES)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_req_valid     (i_valid),
        .i_req_stall     (o_stall),
        .i_mode          (i_mode),
        .i_table_select  (i_table_select),
        .i_stage         (i_stage),
        .i_entry_index   (i_entry_index),
        .i_entry_value   (i_entry_value),
        .i_temperature   (i_temperature),
        .i_voltage       (i_voltage),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_exposure_value(o_exposure_value),
        .i_status        (o_status),
        .o_outstanding   (outstanding),
        .o_failures      (failures)
    );

    // hold off results for a long stretch once armed, else stall at random
    always @(posedge i_clk) begin
        if (hold_arm && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            i_stall    <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("light_voltage_to_exposure_value_top_tb NOT OK");
            $finish;
        end
    end

    task automatic send_request(
        input t_mode      mode,
        input t_sel       sel,
        input logic [2:0] stage,
        input logic [5:0] idx,
        input logic [7:0] val,
        input logic [7:0] temp,
        input logic [7:0] volt
    );
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_mode         <= mode;
        i_table_select <= sel;
        i_stage        <= stage;
        i_entry_index  <= idx;
        i_entry_value  <= val;
        i_temperature  <= temp;
        i_voltage      <= volt;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_table_write(input t_sel sel, input logic [2:0] stage,
                                    input logic [5:0] idx, input logic [7:0] val);
        send_request(MODE_WRITE, sel, stage, idx, val, 8'($urandom), 8'($urandom));
    endtask

    task automatic send_query(input logic [2:0] stage, input logic [7:0] temp,
                              input logic [7:0] volt);
        send_request(MODE_QUERY, t_sel'($urandom_range(3)), stage, 6'($urandom),
                     8'($urandom), temp, volt);
    endtask

    task automatic send_random_request();
        t_mode      mode;
        t_sel       sel;
        logic [2:0] stage;
        logic [5:0] idx;
        logic [7:0] val;
        mode  = ($urandom_range(99) < 60) ? MODE_QUERY : MODE_WRITE;
        sel   = t_sel'($urandom_range(3));
        stage = ($urandom_range(9) == 0) ? 3'($urandom_range(7, STAGES))
                                         : 3'($urandom_range(STAGES - 1));
        idx   = (sel == SEL_TEMP || $urandom_range(7) == 0) ? 6'($urandom_range(63))
                                                            : 6'($urandom_range(15));
        case ($urandom_range(7))
            0:       val = 8'h00;
            1:       val = 8'hFF;
            default: val = 8'($urandom);
        endcase
        send_request(mode, sel, stage, idx, val, 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (outstanding != 0);
    endtask

    task automatic write_offset(input logic [7:0] offset);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= offset;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_random_phase(input int sender_pct, input int receiver_pct,
                                    input logic [7:0] offset, input int count);
        write_offset(offset);
        send_idle_pct = sender_pct;
        recv_idle_pct <= receiver_pct;
        repeat (count) begin
            send_random_request();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_offset(8'h00);

        // fill every table entry so no query reads an unwritten one
        for (int s = 0; s < STAGES; s++) begin
            for (int e = 0; e < LVE_PER_STAGE; e++) begin
                send_table_write(SEL_BASE, 3'(s), 6'(e), 8'($urandom));
                send_table_write(SEL_PAIR, 3'(s), 6'(e), 8'($urandom));
                send_table_write(SEL_PATTERN, 3'(s), 6'(e), 8'($urandom));
            end
        end
        for (int e = 0; e < LVE_TEMP_DEPTH; e++) begin
            send_table_write(SEL_TEMP, 3'($urandom), 6'(e), 8'($urandom));
        end

        // cap: full base, all sixteen pattern bits, largest correction
        send_table_write(SEL_BASE, 3'd0, 6'd0, 8'hFF);
        send_table_write(SEL_PAIR, 3'd0, 6'd0, 8'hFF);
        send_table_write(SEL_PATTERN, 3'd0, 6'd15, 8'hFF);
        send_table_write(SEL_TEMP, 3'd7, 6'd63, 8'h7F);
        send_query(3'd0, 8'hFF, 8'h0F);
        // floor: zero base, most negative correction
        send_table_write(SEL_BASE, 3'd4, 6'd15, 8'h00);
        send_table_write(SEL_TEMP, 3'd0, 6'd0, 8'h80);
        send_query(3'd4, 8'h00, 8'hFF);
        // exactly 255 with eight kept bits, then one kept bit
        send_table_write(SEL_BASE, 3'd1, 6'd0, 8'h80);
        send_table_write(SEL_PAIR, 3'd1, 6'd0, 8'h00);
        send_table_write(SEL_PATTERN, 3'd1, 6'd0, 8'hFF);
        send_table_write(SEL_TEMP, 3'd2, 6'd1, 8'd119);
        send_query(3'd1, 8'h04, 8'h07);
        send_query(3'd1, 8'h07, 8'h00);
        // bad stage on queries and writes
        send_query(3'd5, 8'h00, 8'h00);
        send_query(3'd7, 8'hFF, 8'hFF);
        send_table_write(SEL_PAIR, 3'd5, 6'd3, 8'h55);
        send_table_write(SEL_PATTERN, 3'd7, 6'd63, 8'hAA);
        // per-stage entry beyond the stage is dropped; a temperature entry past 15 is kept
        send_table_write(SEL_BASE, 3'd2, 6'd16, 8'hAA);
        send_table_write(SEL_PAIR, 3'd3, 6'd63, 8'h00);
        send_query(3'd2, 8'h80, 8'h00);
        send_table_write(SEL_TEMP, 3'd4, 6'd32, 8'h00);
        send_query(3'd3, 8'h80, 8'hF0);

        run_random_phase(22, 84, 8'hFF, PHASE_REQUESTS);
        run_random_phase(84, 22, 8'($urandom_range(1, 254)), PHASE_REQUESTS);
        write_offset(8'($urandom_range(1, 127)));
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_arm <= 1'b1;
        repeat (PHASE_REQUESTS / 2) begin
            send_random_request();
        end
        run_random_phase(0, 0, 8'h00, PHASE_REQUESTS / 2);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("light_voltage_to_exposure_value_top_tb OK");
        end else begin
            $display("light_voltage_to_exposure_value_top_tb NOT OK");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/lve_pkg.sv
rtl/lve_front.sv
rtl/lve_lookup.sv
rtl/lve_pattern.sv
rtl/lve_sum.sv
rtl/light_voltage_to_exposure_value_top.sv
verif/light_voltage_to_exposure_value_checker.sv
verif/light_voltage_to_exposure_value_top_tb.sv
